// ----- src/front_middle_back_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Front-middle-back queue assertion macros
// Shared property shapes for the queue's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH
`define FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define FMBQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset only
`define FMBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/fmbq_pkg.sv -----
// ----------------------------------------------------------------------------
// Front-middle-back queue package
// Sizes, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package fmbq_pkg;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;
    localparam int IN_TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int IN_TUSER_W   = ((OP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = ((ST_W + 7) / 8) * 8;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell: shift right from pos (insert) or left into pos (remove)
    typedef struct packed {
        logic ins;
        logic rem;
        idx_t pos;
    } cell_ctrl_t;

endpackage

// ----- src/fmbq_cell.sv -----
// ----------------------------------------------------------------------------
// Queue cell
// Holds one word; takes the left neighbor, the right neighbor or the pushed
// word, or holds, as the broadcast control and its own position decide.
// ----------------------------------------------------------------------------
module fmbq_cell (
    input  logic                   aclk,
    input  fmbq_pkg::cell_ctrl_t   ctrl,
    input  fmbq_pkg::idx_t         cell_idx,
    input  fmbq_pkg::word_t        left_word,
    input  fmbq_pkg::word_t        right_word,
    input  fmbq_pkg::word_t        push_word,
    output fmbq_pkg::word_t        word_q
);

    fmbq_pkg::word_t word_reg;
    fmbq_pkg::word_t word_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.ins) begin
            if (cell_idx > ctrl.pos) begin
                word_next = left_word;
            end else if (cell_idx == ctrl.pos) begin
                word_next = push_word;
            end
        end else if (ctrl.rem) begin
            // close the gap left by the removed word
            if (cell_idx >= ctrl.pos) begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_q = word_reg;

endmodule

// ----- src/front_middle_back_queue.sv -----
// ----------------------------------------------------------------------------
// Front-middle-back queue
// Ordered queue of signed words with push and pop at front, middle and back.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata (low bit up)        | tuser
//  s_      | in  | push_value                | operation
//  m_      | out | pop_value, fill_count     | status
//
//  One operation per cycle while m_ does not stall: every cell shifts or holds
//  in parallel from the count and the operation, and the result is registered.
//  A new word is taken whenever the output register is empty or being drained.
//  Reset clears the count and the output valid; cell contents are not reset.
//  Stalls on m_ hold the result and back-pressure s_ through s_tready.
// ----------------------------------------------------------------------------
`include "front_middle_back_queue_defines.svh"

module front_middle_back_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fmbq_pkg::IN_TDATA_W-1:0]     s_tdata,   // push_value
    input  logic [fmbq_pkg::IN_TUSER_W-1:0]     s_tuser,   // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fmbq_pkg::OUT_TDATA_W-1:0]    m_tdata,   // pop_value, fill_count
    output logic [fmbq_pkg::OUT_TUSER_W-1:0]    m_tuser    // status
);

    localparam fmbq_pkg::cnt_t FULL_CNT = fmbq_pkg::CNT_W'(fmbq_pkg::DEPTH);

    fmbq_pkg::cnt_t       cnt_reg;
    fmbq_pkg::cnt_t       cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    fmbq_pkg::word_t      out_val_reg;
    fmbq_pkg::word_t      out_val_next;
    fmbq_pkg::status_t    out_st_reg;
    fmbq_pkg::status_t    out_st_next;
    fmbq_pkg::cnt_t       out_cnt_reg;

    fmbq_pkg::cell_ctrl_t ctrl;
    fmbq_pkg::word_t      cell_q [fmbq_pkg::DEPTH];
    fmbq_pkg::word_t      push_word;
    fmbq_pkg::op_t        op;
    fmbq_pkg::cnt_t       cnt_dec;
    logic                 s_acc;

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_acc     = s_tvalid && s_tready;
    assign push_word = s_tdata[fmbq_pkg::DATA_WIDTH-1:0];
    assign op        = fmbq_pkg::op_t'(s_tuser[fmbq_pkg::OP_W-1:0]);
    assign cnt_dec   = cnt_reg - fmbq_pkg::CNT_W'(1);

    // Decode the operation into a broadcast cell control and the result
    always_comb begin
        ctrl         = '0;
        cnt_next     = cnt_reg;
        out_val_next = '0;
        out_st_next  = fmbq_pkg::ST_DONE;
        unique case (op)
            fmbq_pkg::OP_PUSH_FRONT, fmbq_pkg::OP_PUSH_MIDDLE, fmbq_pkg::OP_PUSH_BACK: begin
                if (cnt_reg == FULL_CNT) begin
                    out_st_next = fmbq_pkg::ST_FULL;
                end else begin
                    ctrl.ins = s_acc;
                    cnt_next = cnt_reg + fmbq_pkg::CNT_W'(1);
                    if (op == fmbq_pkg::OP_PUSH_FRONT) begin
                        ctrl.pos = '0;
                    end else if (op == fmbq_pkg::OP_PUSH_MIDDLE) begin
                        ctrl.pos = cnt_reg[fmbq_pkg::CNT_W-1:1];
                    end else begin
                        ctrl.pos = cnt_reg[fmbq_pkg::IDX_W-1:0];
                    end
                end
            end
            fmbq_pkg::OP_POP_FRONT, fmbq_pkg::OP_POP_MIDDLE, fmbq_pkg::OP_POP_BACK: begin
                if (cnt_reg == '0) begin
                    out_val_next = '1;
                    out_st_next  = fmbq_pkg::ST_EMPTY;
                end else begin
                    ctrl.rem = s_acc;
                    cnt_next = cnt_dec;
                    if (op == fmbq_pkg::OP_POP_FRONT) begin
                        ctrl.pos = '0;
                    end else if (op == fmbq_pkg::OP_POP_MIDDLE) begin
                        ctrl.pos = cnt_dec[fmbq_pkg::CNT_W-1:1];
                    end else begin
                        ctrl.pos = cnt_dec[fmbq_pkg::IDX_W-1:0];
                    end
                    out_val_next = cell_q[ctrl.pos];
                end
            end
            default: begin
                // unused codes: no change, report the count
            end
        endcase
    end

    for (genvar i = 0; i < fmbq_pkg::DEPTH; i++) begin : g_cell
        fmbq_pkg::word_t left_w;
        fmbq_pkg::word_t right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = cell_q[i-1];
        end
        if (i == fmbq_pkg::DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_q[i+1];
        end
        fmbq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (fmbq_pkg::IDX_W'(i)),
            .left_word  (left_w),
            .right_word (right_w),
            .push_word  (push_word),
            .word_q     (cell_q[i])
        );
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_acc) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_acc) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_val_reg <= out_val_next;
            out_st_reg  <= out_st_next;
            out_cnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fmbq_pkg::OUT_TDATA_W'({out_cnt_reg, out_val_reg});
    assign m_tuser  = fmbq_pkg::OUT_TUSER_W'(out_st_reg);

    `FMBQ_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= FULL_CNT, "fill count beyond depth")
    `FMBQ_ASSERT_NOW(a_ctrl_excl, 1'b1, !(ctrl.ins && ctrl.rem), "insert and remove together")
    `FMBQ_ASSERT_NEXT(a_acc_valid, s_acc, m_tvalid && out_cnt_reg == cnt_reg, "result not presented")
    `FMBQ_ASSERT_NEXT(a_push_grow, ctrl.ins, cnt_reg == $past(cnt_reg) + fmbq_pkg::CNT_W'(1), "push did not grow count")
    `FMBQ_ASSERT_NEXT(a_empty_pop, s_acc && cnt_reg == '0 && (op == fmbq_pkg::OP_POP_FRONT || op == fmbq_pkg::OP_POP_MIDDLE || op == fmbq_pkg::OP_POP_BACK), out_st_reg == fmbq_pkg::ST_EMPTY && out_val_reg == '1, "empty pop not flagged")

endmodule

// ----- tb/tb_front_middle_back_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-middle-back queue testbench
// Streams push and pop words into the queue with random gaps and stalls on
// both channels. A scoreboard keeps its own copy of the queue contents,
// predicts each result word and compares it field by field with the output.
// ----------------------------------------------------------------------------
module tb_front_middle_back_queue;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 600;
    localparam int MAX_PRINTS    = 40;
    localparam logic [fmbq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [fmbq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        fmbq_pkg::word_t   value;
        fmbq_pkg::status_t status;
        fmbq_pkg::cnt_t    fill;
    } qresult_t;

    class fmbq_scoreboard;
        fmbq_pkg::word_t contents[$];
        qresult_t        pending_results[$];
        int              errors;
        int              n_ops;
        int              n_full;
        int              n_empty;
        int              peak;

        function new();
            errors  = 0;
            n_ops   = 0;
            n_full  = 0;
            n_empty = 0;
            peak    = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endtask

        // Apply one accepted word to the shadow queue and queue up its result
        function void note(input logic [fmbq_pkg::OP_W-1:0] op,
                           input fmbq_pkg::word_t value);
            qresult_t r;
            int       n;
            int       pos;
            r.value  = '0;
            r.status = fmbq_pkg::ST_DONE;
            n        = contents.size();
            n_ops++;
            case (op)
                fmbq_pkg::OP_PUSH_FRONT, fmbq_pkg::OP_PUSH_MIDDLE,
                fmbq_pkg::OP_PUSH_BACK: begin
                    if (n >= fmbq_pkg::DEPTH) begin
                        r.status = fmbq_pkg::ST_FULL;
                        n_full++;
                    end else if (op == fmbq_pkg::OP_PUSH_FRONT) begin
                        contents.push_front(value);
                    end else if (op == fmbq_pkg::OP_PUSH_BACK || n == 0) begin
                        contents.insert(n, value);
                    end else begin
                        // right-hand middle for an even count
                        contents.insert(n / 2, value);
                    end
                end
                fmbq_pkg::OP_POP_FRONT, fmbq_pkg::OP_POP_MIDDLE,
                fmbq_pkg::OP_POP_BACK: begin
                    if (n == 0) begin
                        r.value  = '1;
                        r.status = fmbq_pkg::ST_EMPTY;
                        n_empty++;
                    end else begin
                        if (op == fmbq_pkg::OP_POP_FRONT) pos = 0;
                        else if (op == fmbq_pkg::OP_POP_MIDDLE) pos = (n - 1) / 2;
                        else pos = n - 1;
                        r.value = contents[pos];
                        contents.delete(pos);
                    end
                end
                default: ;
            endcase
            r.fill = fmbq_pkg::cnt_t'(contents.size());
            if (contents.size() > peak) peak = contents.size();
            pending_results.insert(pending_results.size(), r);
        endfunction

        task check(input logic [fmbq_pkg::OUT_TDATA_W-1:0] tdata,
                   input logic [fmbq_pkg::OUT_TUSER_W-1:0] tuser);
            qresult_t          r;
            fmbq_pkg::word_t   got_value;
            fmbq_pkg::cnt_t    got_fill;
            fmbq_pkg::status_t got_status;
            got_value  = tdata[fmbq_pkg::DATA_WIDTH-1:0];
            got_fill   = tdata[fmbq_pkg::DATA_WIDTH +: fmbq_pkg::CNT_W];
            got_status = fmbq_pkg::status_t'(tuser[fmbq_pkg::ST_W-1:0]);
            if (pending_results.size() == 0) begin
                report($sformatf("result word with nothing outstanding (value %h)", got_value));
                return;
            end
            r = pending_results.pop_front();
            if (got_value !== r.value)
                report($sformatf("pop_value %h, predicted %h", got_value, r.value));
            if (got_status !== r.status)
                report($sformatf("status %0d, predicted %0d", got_status, r.status));
            if (got_fill !== r.fill)
                report($sformatf("fill_count %0d, predicted %0d", got_fill, r.fill));
        endtask
    endclass

    logic                                   aclk     = 1'b0;
    logic                                   aresetn  = 1'b0;
    logic                                   s_tvalid = 1'b0;
    logic                                   s_tready;
    logic [fmbq_pkg::IN_TDATA_W-1:0]        s_tdata  = '0;   // push_value
    logic [fmbq_pkg::IN_TUSER_W-1:0]        s_tuser  = '0;   // operation
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    logic [fmbq_pkg::OUT_TDATA_W-1:0]       m_tdata;         // pop_value, fill_count
    logic [fmbq_pkg::OUT_TUSER_W-1:0]       m_tuser;         // status

    fmbq_scoreboard sb;
    int  cycle_count = 0;
    int  rx_hold     = 0;
    int  long_holds  = 0;
    bit  tx_steady   = 1'b0;
    bit  rx_steady   = 1'b0;

    front_middle_back_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one word after a random gap (none when tx_steady); valid stays high into the next call
    task automatic send_word(input logic [fmbq_pkg::OP_W-1:0] op,
                             input fmbq_pkg::word_t value);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fmbq_pkg::IN_TUSER_W'(op);
        s_tdata  <= fmbq_pkg::IN_TDATA_W'(value);
        do @(posedge aclk); while (!s_tready);
        sb.note(op, value);
    endtask

    // Drop valid and hold until every outstanding result has drained
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [fmbq_pkg::OP_W-1:0] pick_op(input int push_pct);
        if ($urandom_range(0, 39) == 0)
            return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        if ($urandom_range(1, 100) <= push_pct)
            return fmbq_pkg::OP_W'($urandom_range(fmbq_pkg::OP_PUSH_BACK,
                                                  fmbq_pkg::OP_PUSH_FRONT));
        return fmbq_pkg::OP_W'($urandom_range(fmbq_pkg::OP_POP_BACK,
                                              fmbq_pkg::OP_POP_FRONT));
    endfunction

    function automatic fmbq_pkg::word_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
                long_holds++;
            end else if (rx_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check(m_tdata, m_tuser);
        end
    end

    initial begin : stimulus
        int sent;
        int phase;
        int len;
        int push_pct;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: pops and spare codes on empty, then extremes in every position
        send_word(fmbq_pkg::OP_POP_FRONT,   32'h1234_5678);
        send_word(fmbq_pkg::OP_POP_MIDDLE,  32'hFFFF_FFFF);
        send_word(fmbq_pkg::OP_POP_BACK,    32'h0000_0000);
        send_word(OP_SPARE_LO,              32'hDEAD_BEEF);
        send_word(OP_SPARE_HI,              32'h0000_0001);
        send_word(fmbq_pkg::OP_PUSH_MIDDLE, 32'h7FFF_FFFF);
        send_word(fmbq_pkg::OP_PUSH_FRONT,  32'h8000_0000);
        send_word(fmbq_pkg::OP_PUSH_BACK,   32'hFFFF_FFFF);
        send_word(fmbq_pkg::OP_PUSH_MIDDLE, 32'h0000_0000);
        send_word(fmbq_pkg::OP_PUSH_MIDDLE, 32'h5555_5555);
        send_word(fmbq_pkg::OP_PUSH_BACK,   32'hAAAA_AAAA);
        send_word(OP_SPARE_LO,              32'h0F0F_0F0F);
        send_word(fmbq_pkg::OP_POP_MIDDLE,  32'h0000_0000);
        send_word(fmbq_pkg::OP_POP_MIDDLE,  32'h0000_0000);
        send_word(fmbq_pkg::OP_POP_FRONT,   32'h0000_0000);
        send_word(fmbq_pkg::OP_POP_BACK,    32'h0000_0000);
        send_word(fmbq_pkg::OP_POP_MIDDLE,  32'h0000_0000);
        send_word(fmbq_pkg::OP_POP_BACK,    32'h0000_0000);
        send_word(fmbq_pkg::OP_POP_FRONT,   32'h0000_0000);
        send_word(fmbq_pkg::OP_PUSH_BACK,   32'h0000_0001);
        send_word(fmbq_pkg::OP_POP_MIDDLE,  32'h0000_0000);
        drain_results();

        // Random phases that swing the fill between empty and full
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            phase++;
            len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                // back up the output while the input keeps offering
                rx_hold   = 80;
                tx_steady = 1'b1;
                push_pct  = 70;
            end
            repeat (len) begin
                send_word(pick_op(push_pct), pick_value());
                sent++;
            end
            if (phase % 5 == 0) drain_results();
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d words checked over %0d random phases, peak fill %0d of %0d",
                 sb.n_ops, phase, sb.peak, fmbq_pkg::DEPTH);
        $display("%0d pushes dropped on full, %0d pops on empty, %0d long output hold-offs",
                 sb.n_full, sb.n_empty, long_holds);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/fmbq_pkg.sv
src/fmbq_cell.sv
src/front_middle_back_queue.sv
tb/tb_front_middle_back_queue.sv
